// File: rtl/lfes_pkg.sv
// shared types and constants for the largest-first entry selection block
// no dependencies; used by lfes_scan and largest_first_entry_selection under rtl
package lfes_pkg;

  // field widths of the request and result items
  localparam int AMT_W = 63;
  localparam int TGT_W = 64;
  localparam int IDX_W = 5;

  // store depth default and the cap on results per selection
  localparam int MAX_ENTRIES_DEF = 32;
  localparam int RESULT_CAP      = 32;
  localparam int RES_W           = $clog2(RESULT_CAP + 1);

  // request kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SELECT = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [AMT_W-1:0] amount;
    logic [TGT_W-1:0] target;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             last;
    logic             empty_res;
    logic             overflow;
  } out_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_EMPTY
  } state_t;

  // control from the sequencer to the scan unit
  typedef struct packed {
    logic start;
    logic issue;
  } scan_ctl_t;

  // status back from the scan unit
  typedef struct packed {
    logic found;
    logic pending;
  } scan_st_t;

endpackage

// File: rtl/lfes_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module lfes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/lfes_scan.sv
// scan unit: one shared compare that tracks the largest untaken entry over a store sweep
// depends on lfes_pkg
module lfes_scan #(
  parameter int MAX_ENTRIES = lfes_pkg::MAX_ENTRIES_DEF,
  parameter int AW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lfes_pkg::scan_ctl_t      ctl,
  input  logic [AW-1:0]            issue_idx,
  input  logic [lfes_pkg::AMT_W-1:0] rd_data,
  input  logic [MAX_ENTRIES-1:0]   taken,
  output lfes_pkg::scan_st_t       st,
  output logic [AW-1:0]            best_idx,
  output logic [lfes_pkg::AMT_W-1:0] best_amt
);
  import lfes_pkg::*;

  logic          p_vld;
  logic [AW-1:0] p_idx;
  logic          found;
  logic          take;

  // ties go to the later position since the sweep runs upward and uses >=
  assign take = p_vld && !taken[p_idx] && (!found || (rd_data >= best_amt));

  // track which address the read data belongs to
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= ctl.issue;
    end
    p_idx <= issue_idx;
  end

  // best-so-far holder
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.start) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
    if (take) begin
      best_idx <= p_idx;
      best_amt <= rd_data;
    end
  end

  assign st.found   = found;
  assign st.pending = p_vld;

`ifndef ASSERT_OFF
  // a new sweep never starts while a read is still in flight
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> !p_vld)
    else $error("scan started with a read in flight");

  // an entry already taken is never chosen again
  a_no_retake: assert property (@(posedge clk) disable iff (rst)
    take |=> !taken[best_idx] || $past(ctl.start))
    else $error("taken entry chosen");

  // once an entry is found the flag holds until the next sweep starts
  a_found_hold: assert property (@(posedge clk) disable iff (rst)
    (found && !ctl.start) |=> found)
    else $error("found flag dropped mid sweep");
`endif

endmodule

// File: rtl/largest_first_entry_selection.sv
// Largest-first entry selection: a load request keeps the block idle and ready for the next one.
// A select request emits one result per pass over the store; each pass sweeps the entries through
// the single read port of the amount memory feeding one compare unit, then goes to the emit state.
// No entries or a target of zero or less gives one empty result through the empty state after the
// request. One request at a time. Reset clears the entry count, taken mask, total and overflow flag;
// the amount memory is not cleared and only data read from positions below the entry count is used.
module largest_first_entry_selection #(
  parameter int MAX_ENTRIES = lfes_pkg::MAX_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lfes_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output lfes_pkg::out_t out_data
);
  import lfes_pkg::*;

  localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > RES_W) ? CNT_W : RES_W;

  state_t state, state_next;

  logic [CNT_W-1:0]       entry_count;
  logic [MAX_ENTRIES-1:0] taken;
  logic [AMT_W-1:0]       total;
  logic                   overflow_flag;
  logic [TGT_W-1:0]       target;
  logic [CNT_W-1:0]       scan_ptr;
  logic [RES_W-1:0]       n_res;

  logic       in_fire, load_fire, sel_fire, store_full, sel_empty;
  logic       out_free, emit_fire, empty_fire, res_last;
  scan_ctl_t  ctl;
  scan_st_t   st;
  logic [AW-1:0]    best_idx;
  logic [AMT_W-1:0] best_amt;
  logic [AMT_W-1:0] rd_data;
  logic [AMT_W:0]   sum;
  logic [AMT_W-1:0] sum_sat;
  logic             reached, cap_hit, all_taken;

  // request decode
  assign in_ready   = (state == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign load_fire  = in_fire && (in_data.kind == KIND_LOAD);
  assign sel_fire   = in_fire && (in_data.kind == KIND_SELECT);
  assign store_full = (entry_count >= CNT_W'(MAX_ENTRIES));
  assign sel_empty  = (entry_count == '0) || (in_data.target == '0) ||
                      in_data.target[TGT_W-1];

  // amount store
  lfes_ram #(
    .WIDTH (AMT_W),
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (load_fire && !store_full),
    .waddr (entry_count[AW-1:0]),
    .wdata (in_data.amount),
    .raddr (scan_ptr[AW-1:0]),
    .rdata (rd_data)
  );

  // shared compare unit
  lfes_scan #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .AW          (AW)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .issue_idx (scan_ptr[AW-1:0]),
    .rd_data   (rd_data),
    .taken     (taken),
    .st        (st),
    .best_idx  (best_idx),
    .best_amt  (best_amt)
  );

  // saturating total and stop conditions for the entry about to be emitted
  assign sum       = {1'b0, total} + {1'b0, best_amt};
  assign sum_sat   = sum[AMT_W] ? {AMT_W{1'b1}} : sum[AMT_W-1:0];
  assign reached   = (sum_sat >= target[AMT_W-1:0]);
  assign cap_hit   = ((n_res + RES_W'(1)) == RES_W'(RESULT_CAP));
  assign all_taken = ((CMP_W'(n_res) + CMP_W'(1)) == CMP_W'(entry_count));
  assign res_last  = reached || cap_hit || all_taken;

  assign out_free   = !out_valid || out_ready;
  assign emit_fire  = (state == ST_EMIT) && out_free;
  assign empty_fire = (state == ST_EMPTY) && out_free;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and scan control
  always_comb begin
    state_next = state;
    ctl.start  = 1'b0;
    ctl.issue  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (sel_fire) begin
          if (sel_empty) begin
            state_next = ST_EMPTY;
          end else begin
            state_next = ST_SCAN;
            ctl.start  = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        ctl.issue = (scan_ptr != entry_count);
        if (!ctl.issue && !st.pending) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          if (res_last) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_SCAN;
            ctl.start  = 1'b1;
          end
        end
      end
      ST_EMPTY: begin
        if (empty_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // store bookkeeping, cleared after every selection
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      taken         <= '0;
      total         <= '0;
      overflow_flag <= 1'b0;
      n_res         <= '0;
    end else if ((emit_fire && res_last) || empty_fire) begin
      entry_count   <= '0;
      taken         <= '0;
      total         <= '0;
      overflow_flag <= 1'b0;
      n_res         <= '0;
    end else if (emit_fire) begin
      taken[best_idx] <= 1'b1;
      total           <= sum_sat;
      n_res           <= n_res + RES_W'(1);
    end else if (load_fire) begin
      if (store_full) begin
        overflow_flag <= 1'b1;
      end else begin
        entry_count <= entry_count + CNT_W'(1);
      end
    end
  end

  // target capture and sweep pointer
  always_ff @(posedge clk) begin
    if (sel_fire) begin
      target <= in_data.target;
    end
    if (rst || ctl.start) begin
      scan_ptr <= '0;
    end else if (ctl.issue) begin
      scan_ptr <= scan_ptr + CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire || empty_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (emit_fire) begin
      out_data.index     <= IDX_W'({{IDX_W{1'b0}}, best_idx});
      out_data.last      <= res_last;
      out_data.empty_res <= 1'b0;
      out_data.overflow  <= overflow_flag;
    end else if (empty_fire) begin
      out_data.index     <= '0;
      out_data.last      <= 1'b1;
      out_data.empty_res <= 1'b1;
      out_data.overflow  <= overflow_flag;
    end
  end

`ifndef ASSERT_OFF
  // entry count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond store depth");

  // a pass always ends with an entry found
  a_emit_found: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> st.found)
    else $error("emit without a chosen entry");

  // taken bits track the number of results given in this selection
  a_taken_count: assert property (@(posedge clk) disable iff (rst)
    $countones(taken) == int'(n_res))
    else $error("taken mask out of step with result count");

  // the final result of a selection clears the entry count and total
  a_clear_after: assert property (@(posedge clk) disable iff (rst)
    ((emit_fire && res_last) || empty_fire) |=> (entry_count == '0) && (total == '0))
    else $error("store not cleared after selection");
`endif

endmodule

// File: tb/largest_first_entry_selection_test.sv
// self-checking testbench for largest_first_entry_selection: directed and random requests,
// a predictor of the picks per selection, and a monitor comparing every result field
// depends on rtl/lfes_pkg.sv and rtl/largest_first_entry_selection.sv
`timescale 1ns / 1ps

module largest_first_entry_selection_test;
  import lfes_pkg::*;

  localparam int NENT = MAX_ENTRIES_DEF;
  localparam logic [AMT_W-1:0] AMT_MAX = {AMT_W{1'b1}};
  localparam logic [TGT_W-1:0] TGT_MAX = {1'b0, {(TGT_W-1){1'b1}}};
  localparam logic [TGT_W-1:0] TGT_MIN = {1'b1, {(TGT_W-1){1'b0}}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // pending requests and expected picks
  in_t  req_q[$];
  out_t pick_q[$];

  // predictor copy of the store
  logic [AMT_W-1:0] held_amt[NENT];
  int unsigned      held_cnt = 0;
  logic             dropped = 1'b0;

  int unsigned sent_cnt = 0;
  int unsigned load_cnt = 0;
  int unsigned sel_cnt = 0;
  int unsigned res_cnt = 0;
  int unsigned err_cnt = 0;

  // no idling on either side in this window of requests
  logic calm;
  assign calm = (sent_cnt >= 140) && (sent_cnt < 220);

  largest_first_entry_selection #(
    .MAX_ENTRIES(NENT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_cnt++;
    $display("mismatch at result %0d: %s got %0h want %0h", res_cnt, what, got, want);
  endtask

  // append to the request and pick queues
  function automatic void add_req(in_t r);
    req_q.insert(req_q.size(), r);
  endfunction

  function automatic void add_pick(out_t p);
    pick_q.insert(pick_q.size(), p);
  endfunction

  // work out the picks that one accepted request causes
  task automatic predict_picks(in_t r);
    logic [31:0]      taken;
    logic [AMT_W-1:0] total;
    logic [63:0]      sum;
    logic [TGT_W-1:0] tgt;
    int unsigned      best;
    int unsigned      n;
    logic             found;
    out_t             p;
    taken = '0;
    total = '0;
    n = 0;
    tgt = r.target;
    if (r.kind == KIND_LOAD) begin
      if (held_cnt < NENT) begin
        held_amt[held_cnt] = r.amount;
        held_cnt++;
      end else begin
        dropped = 1'b1;
      end
    end else begin
      if (held_cnt == 0 || tgt == '0 || tgt[TGT_W-1]) begin
        // nothing to select
        p.index = '0;
        p.last = 1'b1;
        p.empty_res = 1'b1;
        p.overflow = dropped;
        add_pick(p);
      end else begin
        while ({1'b0, total} < tgt && n < RESULT_CAP && n < held_cnt) begin
          // largest untaken entry, larger position wins ties
          found = 1'b0;
          best = 0;
          for (int unsigned i = 0; i < held_cnt; i++) begin
            if (!taken[i] && (!found || held_amt[i] >= held_amt[best])) begin
              best = i;
              found = 1'b1;
            end
          end
          taken[best] = 1'b1;
          sum = {1'b0, total} + {1'b0, held_amt[best]};
          total = sum[63] ? AMT_MAX : sum[AMT_W-1:0];
          p.index = best[IDX_W-1:0];
          p.last = ({1'b0, total} >= tgt) || (n + 1 == held_cnt) || (n + 1 == RESULT_CAP);
          p.empty_res = 1'b0;
          p.overflow = dropped;
          add_pick(p);
          n++;
        end
      end
      held_cnt = 0;
      dropped = 1'b0;
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_t mk_load(logic [AMT_W-1:0] amt);
    in_t r;
    logic [63:0] junk;
    junk = rand64();
    r.kind = KIND_LOAD;
    r.amount = amt;
    r.target = junk;
    return r;
  endfunction

  function automatic in_t mk_select(logic [TGT_W-1:0] tgt);
    in_t r;
    logic [63:0] junk;
    junk = rand64();
    r.kind = KIND_SELECT;
    r.amount = junk[AMT_W-1:0];
    r.target = tgt;
    return r;
  endfunction

  // random amount in one of several styles
  function automatic logic [AMT_W-1:0] rand_amount(int unsigned style);
    logic [63:0] r;
    r = rand64();
    case (style)
      0: return r[AMT_W-1:0];
      1: return AMT_W'($urandom_range(0, 15));
      2: return ($urandom_range(0, 3) == 0) ? AMT_MAX : r[AMT_W-1:0] | {2'b11, {(AMT_W-2){1'b0}}};
      default: return AMT_W'($urandom_range(0, 1000));
    endcase
  endfunction

  // driver: present queued requests, idle at random
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_picks(in_data);
        sent_cnt++;
        if (in_data.kind == KIND_LOAD) load_cnt++;
        else sel_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (req_q.size() > 0 && (calm || $urandom_range(0, 99) >= 27)) begin
          in_valid <= 1'b1;
          in_data <= req_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result against the oldest expected pick
  always @(posedge clk) begin : mon
    out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pick_q.size() == 0) begin
          report_mismatch("unexpected result, index", 64'(out_data.index), 64'd0);
        end else begin
          want = pick_q.pop_front();
          if (out_data.index !== want.index)
            report_mismatch("index", 64'(out_data.index), 64'(want.index));
          if (out_data.last !== want.last)
            report_mismatch("last", 64'(out_data.last), 64'(want.last));
          if (out_data.empty_res !== want.empty_res)
            report_mismatch("empty_res", 64'(out_data.empty_res), 64'(want.empty_res));
          if (out_data.overflow !== want.overflow)
            report_mismatch("overflow", 64'(out_data.overflow), 64'(want.overflow));
        end
        res_cnt++;
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 27);
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned nload;
    int unsigned astyle;
    int unsigned pick;
    logic [AMT_W-1:0] a;
    logic [63:0] acc;
    logic [TGT_W-1:0] tgt;

    // select with no entries
    add_req(mk_select(64'd5));
    // single zero entry never reaching its target
    add_req(mk_load('0));
    add_req(mk_select(64'd1));
    // total saturates past the largest target
    for (int i = 0; i < 3; i++) add_req(mk_load({2'b11, {(AMT_W-2){1'b0}}}));
    add_req(mk_select(TGT_MAX));
    // zero and most negative targets with entries present
    add_req(mk_load(AMT_W'(3)));
    add_req(mk_load(AMT_W'(9)));
    add_req(mk_select('0));
    add_req(mk_load(AMT_W'(4)));
    add_req(mk_select(TGT_MIN));
    // equal amounts, every entry emitted
    for (int i = 0; i < 3; i++) add_req(mk_load(AMT_W'(5)));
    add_req(mk_select(64'd100));
    // largest amount meets the target alone
    add_req(mk_load(AMT_MAX));
    add_req(mk_load(AMT_W'(1)));
    add_req(mk_select(TGT_MAX));

    // random sequences of loads closed by a selection
    while (req_q.size() < 360) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) nload = $urandom_range(1, 6);
      else if (pick < 85) nload = $urandom_range(7, 20);
      else if (pick < 95) nload = $urandom_range(28, 36);
      else nload = 0;
      astyle = $urandom_range(0, 3);
      acc = '0;
      for (int unsigned i = 0; i < nload; i++) begin
        a = rand_amount(($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : astyle);
        add_req(mk_load(a));
        if (i < NENT) begin
          acc = acc + {1'b0, a};
          if (acc[63]) acc = {1'b0, AMT_MAX};
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) tgt = acc >> $urandom_range(0, 3);
      else if (pick < 60) tgt = acc;
      else if (pick < 70) tgt = (acc < {1'b0, AMT_MAX}) ? acc + 1 : acc;
      else if (pick < 78) tgt = '0;
      else if (pick < 86) tgt = rand64() | TGT_MIN;
      else if (pick < 93) tgt = rand64();
      else tgt = TGT_MAX;
      add_req(mk_select(tgt));
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // every request taken, every pick seen, then a quiet tail
    while (req_q.size() > 0 || in_valid) @(posedge clk);
    while (pick_q.size() > 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("covered %0d requests: %0d loads and %0d selections", sent_cnt, load_cnt, sel_cnt);
    $display("checked %0d results, %0d mismatches", res_cnt, err_cnt);
    if (err_cnt == 0 && pick_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("timeout with %0d picks still expected", pick_q.size());
    $display("status: fail");
    $finish;
  end

endmodule
